>>> hw/rtl/rsie_pkg.sv
// ----------------------------------------------------------------------------
// rsie_pkg: shared types and constants
// Operation codes, queue entry type and sizes of the instruction executor.
// ----------------------------------------------------------------------------
package rsie_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int PC_LINES  = 65536;
  localparam int PC_W      = $clog2(PC_LINES);
  localparam logic [4:0] SP_REG = 5'd2;
  localparam logic [4:0] RA_REG = 5'd1;
  localparam logic [15:0] STACK_LIMIT_RST = 16'd1024;

  typedef enum logic [4:0] {
    OP_LI = 5'd0, OP_LA = 5'd1, OP_MV = 5'd2, OP_ADD = 5'd3, OP_ADDI = 5'd4,
    OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7, OP_DIVU = 5'd8, OP_REM = 5'd9,
    OP_UREM = 5'd10, OP_SLLI = 5'd11, OP_XOR = 5'd12, OP_XORI = 5'd13,
    OP_SEQZ = 5'd14, OP_SNEZ = 5'd15, OP_SLT = 5'd16, OP_SGT = 5'd17,
    OP_J = 5'd18, OP_BNEZ = 5'd19, OP_JAL = 5'd20, OP_RET = 5'd21,
    OP_LW = 5'd22, OP_SW = 5'd23
  } op_t;

  // Instruction class set by the front end.
  typedef enum logic [1:0] {
    CL_ALU = 2'd0, CL_DIV = 2'd1, CL_MEM = 2'd2, CL_CTL = 2'd3
  } cls_t;

  typedef struct packed {
    logic [4:0]  mode;
    cls_t        cls;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
    logic [15:0] target;
  } instr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_LOAD, ST_OUT
  } exec_state_t;

endpackage

>>> hw/rtl/rsie_front.sv
// ----------------------------------------------------------------------------
// rsie_front: instruction intake
// Accepts items, classifies them and keeps a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rsie_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           in_mode,
  input  logic [4:0]           in_rd,
  input  logic [4:0]           in_ra,
  input  logic [4:0]           in_rb,
  input  logic [31:0]          in_imm,
  input  logic [15:0]          in_target,
  output logic                 q_valid,
  input  logic                 q_pop,
  output rsie_pkg::instr_t     q_data
);
  import rsie_pkg::*;

  instr_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cls_t       cls;

  always_comb begin
    unique case (in_mode) inside
      OP_DIV, OP_DIVU, OP_REM, OP_UREM: cls = CL_DIV;
      OP_LW, OP_SW:                     cls = CL_MEM;
      OP_J, OP_BNEZ, OP_JAL, OP_RET:    cls = CL_CTL;
      default:                          cls = CL_ALU;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{mode: in_mode, cls: cls, rd: in_rd, ra: in_ra, rb: in_rb,
                       imm: in_imm, target: in_target};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> hw/rtl/rsie_div.sv
// ----------------------------------------------------------------------------
// rsie_div: iterative divider
// Restoring division, one quotient bit per cycle, with RISC-V special cases.
// ----------------------------------------------------------------------------
module rsie_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        is_signed,
  input  logic        want_rem,
  output logic        done,
  output logic [31:0] result
);
  logic [31:0] quo_r, rem_r, dvs_r, a_r;
  logic [5:0]  cnt_r;
  logic        busy_r, neg_q_r, neg_r_r, zero_r, rem_sel_r;
  logic [32:0] trial;
  logic [31:0] rem_shift;
  logic [31:0] qf, rf;

  assign rem_shift = {rem_r[30:0], quo_r[31]};
  assign trial     = {1'b0, rem_shift} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= 6'd0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        cnt_r     <= 6'd32;
        a_r       <= a;
        zero_r    <= (b == 32'd0);
        rem_sel_r <= want_rem;
        neg_q_r   <= is_signed && (a[31] ^ b[31]);
        neg_r_r   <= is_signed && a[31];
        quo_r     <= (is_signed && a[31]) ? -a : a;
        dvs_r     <= (is_signed && b[31]) ? -b : b;
        rem_r     <= 32'd0;
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_shift;
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Overflow of the most negative value by -1 falls out of the magnitudes.
  assign qf = neg_q_r ? -quo_r : quo_r;
  assign rf = neg_r_r ? -rem_r : rem_r;
  assign result = zero_r ? (rem_sel_r ? a_r : 32'hFFFF_FFFF) : (rem_sel_r ? rf : qf);

endmodule

>>> hw/rtl/rsie_back.sv
// ----------------------------------------------------------------------------
// rsie_back: execution engine
// Register file, data memory, program counter and result register.
// ----------------------------------------------------------------------------
module rsie_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  rsie_pkg::instr_t  q_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_pc,
  output logic              out_fault,
  output logic              out_wrote,
  output logic [31:0]       out_value
);
  import rsie_pkg::*;

  exec_state_t st_r, st_nxt;
  instr_t      ins_r;
  logic [31:0] rf_r [32];
  logic [31:0] a_r, b_r, d_r, ra1_r;
  logic [PC_W-1:0] pc_r;
  logic [15:0] lim_r;
  logic [7:0]  mem0 [MEM_BYTES/4];
  logic [7:0]  mem1 [MEM_BYTES/4];
  logic [7:0]  mem2 [MEM_BYTES/4];
  logic [7:0]  mem3 [MEM_BYTES/4];
  logic [7:0]  rd0_r, rd1_r, rd2_r, rd3_r;
  logic [MEM_AW-1:0] addr;
  logic [MEM_AW-3:0] w0, w1, w2, w3;
  logic [1:0]  bsel_r;
  logic [32:0] eaddr;
  logic        mfault, do_st, div_start, div_done, fin;
  logic [31:0] div_res, alu_val, lw_val;
  logic [63:0] prod;
  logic        alu_wr, fin_wr, fin_fault;
  logic [31:0] fin_val;
  logic [PC_W-1:0] jpc;
  logic [7:0]  sb [4];
  logic [7:0]  lb [4];

  assign eaddr  = {a_r[31], a_r} + {ins_r.imm[31], ins_r.imm};
  assign mfault = eaddr[32] || (eaddr > 33'(MEM_BYTES - 4)) ||
                  (ins_r.ra == SP_REG && !ins_r.imm[31] && ins_r.imm > {16'd0, lim_r});
  assign addr   = eaddr[MEM_AW-1:0];
  assign prod   = a_r * b_r;

  always_comb begin
    alu_wr  = 1'b1;
    alu_val = 32'd0;
    jpc     = pc_r;
    case (ins_r.mode)
      OP_LI, OP_LA: alu_val = ins_r.imm;
      OP_MV:   alu_val = a_r;
      OP_ADD:  alu_val = a_r + b_r;
      OP_ADDI: alu_val = a_r + ins_r.imm;
      OP_SUB:  alu_val = a_r - b_r;
      OP_MUL:  alu_val = prod[31:0];
      OP_SLLI: alu_val = a_r << ins_r.imm[4:0];
      OP_XOR:  alu_val = a_r ^ b_r;
      OP_XORI: alu_val = a_r ^ ins_r.imm;
      OP_SEQZ: alu_val = {31'd0, a_r == 32'd0};
      OP_SNEZ: alu_val = {31'd0, a_r != 32'd0};
      OP_SLT:  alu_val = {31'd0, $signed(a_r) < $signed(b_r)};
      OP_SGT:  alu_val = {31'd0, $signed(a_r) > $signed(b_r)};
      OP_J:    begin alu_wr = 1'b0; jpc = PC_W'(ins_r.target); end
      OP_BNEZ: begin
        alu_wr = 1'b0;
        if (d_r != 32'd0) jpc = PC_W'(ins_r.target);
      end
      OP_JAL:  begin alu_val = 32'(pc_r); jpc = PC_W'(ins_r.target); end
      OP_RET:  begin alu_wr = 1'b0; jpc = ra1_r[PC_W-1:0]; end
      default: alu_wr = 1'b0;
    endcase
  end

  // Byte lanes: byte k of the word lands in bank (addr+k) mod 4.
  always_comb begin
    w0 = addr[MEM_AW-1:2] + (addr[1:0] > 2'd0 ? 1'b1 : 1'b0);
    w1 = addr[MEM_AW-1:2] + (addr[1:0] > 2'd1 ? 1'b1 : 1'b0);
    w2 = addr[MEM_AW-1:2] + (addr[1:0] > 2'd2 ? 1'b1 : 1'b0);
    w3 = addr[MEM_AW-1:2];
    for (int k = 0; k < 4; k++) sb[k] = d_r[8*k +: 8];
    lb[0] = rd0_r; lb[1] = rd1_r; lb[2] = rd2_r; lb[3] = rd3_r;
    lw_val = {lb[2'(bsel_r + 2'd3)], lb[2'(bsel_r + 2'd2)],
              lb[2'(bsel_r + 2'd1)], lb[bsel_r]};
  end

  assign do_st = (st_r == ST_EXEC) && ins_r.cls == CL_MEM && ins_r.mode == OP_SW && !mfault;

  always_ff @(posedge clk) begin
    if (do_st) begin
      mem0[w0] <= sb[2'(2'd0 - addr[1:0])];
      mem1[w1] <= sb[2'(2'd1 - addr[1:0])];
      mem2[w2] <= sb[2'(2'd2 - addr[1:0])];
      mem3[w3] <= sb[2'(2'd3 - addr[1:0])];
    end
    rd0_r <= mem0[w0]; rd1_r <= mem1[w1]; rd2_r <= mem2[w2]; rd3_r <= mem3[w3];
    bsel_r <= addr[1:0];
  end

  assign div_start = (st_r == ST_EXEC) && ins_r.cls == CL_DIV;

  rsie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(a_r), .b(b_r),
    .is_signed(ins_r.mode == OP_DIV || ins_r.mode == OP_REM),
    .want_rem(ins_r.mode == OP_REM || ins_r.mode == OP_UREM),
    .done(div_done), .result(div_res)
  );

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_wr    = 1'b0;
    fin_fault = 1'b0;
    fin_val   = 32'd0;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin q_pop = 1'b1; st_nxt = ST_EXEC; end
      ST_EXEC: begin
        if (ins_r.cls == CL_DIV) st_nxt = ST_DIV;
        else if (ins_r.cls == CL_MEM) begin
          if (mfault) begin fin = 1'b1; fin_fault = 1'b1; st_nxt = ST_OUT; end
          else if (ins_r.mode == OP_LW) st_nxt = ST_LOAD;
          else begin fin = 1'b1; st_nxt = ST_OUT; end
        end else begin
          fin = 1'b1; fin_wr = alu_wr; fin_val = alu_wr ? alu_val : 32'd0;
          st_nxt = ST_OUT;
        end
      end
      ST_DIV: if (div_done) begin
        fin = 1'b1; fin_wr = 1'b1; fin_val = div_res; st_nxt = ST_OUT;
      end
      ST_LOAD: begin fin = 1'b1; fin_wr = 1'b1; fin_val = lw_val; st_nxt = ST_OUT; end
      ST_OUT: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = (st_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ins_r <= q_data;
      a_r   <= rf_r[q_data.ra];
      b_r   <= rf_r[q_data.rb];
      d_r   <= rf_r[q_data.rd];
      ra1_r <= rf_r[RA_REG];
    end
    if (fin) begin
      out_fault <= fin_fault;
      out_wrote <= fin_wr;
      out_value <= fin_val;
      out_pc    <= 16'(fin_fault ? pc_r :
                       ((ins_r.cls == CL_CTL || ins_r.cls == CL_ALU) ? jpc : pc_r) + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      pc_r  <= '0;
      lim_r <= STACK_LIMIT_RST;
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) lim_r <= cfg_wdata;
      if (fin && !fin_fault) begin
        pc_r <= ((ins_r.cls == CL_CTL || ins_r.cls == CL_ALU) ? jpc : pc_r) + 1'b1;
        if (fin_wr) rf_r[ins_r.rd] <= fin_val;
      end
    end
  end

endmodule

>>> hw/rtl/riscv_subset_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// riscv_subset_instruction_executor_unit: decoded instruction executor
// Executes one decoded instruction per item on registers and data memory.
// ----------------------------------------------------------------------------
// The in_ channel carries one decoded instruction per item; the out_ channel
// returns one result item per instruction, in order. A two-entry queue
// decouples intake from execution, so up to two items are taken while the
// executor is busy or the receiver stalls.
// ALU items, control items and stores pass the execute and output states;
// loads add a load state for the registered memory read, and divide and
// remainder wait in the divide state for the one-bit-per-cycle divider. A
// result is held in the output register until out_tready; the next item
// starts after it is taken. Reset clears registers to zero, pc to zero and
// the stack offset limit to 1024; data memory holds no reset value. cfg_we
// writes the limit, for the user to use only while idle; not enforced.
// ----------------------------------------------------------------------------
module riscv_subset_instruction_executor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[4:0], dest_reg[9:5], src_a_reg[14:10], src_b_reg[19:15],
  // immediate[51:20], target_line[67:52]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_pc[15:0], fault[16], wrote_reg[17], write_value[49:18]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import rsie_pkg::*;

  logic        q_valid, q_pop;
  instr_t      q_data;
  logic [15:0] pc;
  logic        flt, wr;
  logic [31:0] val;

  rsie_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tdata[4:0]), .in_rd(in_tdata[9:5]), .in_ra(in_tdata[14:10]),
    .in_rb(in_tdata[19:15]), .in_imm(in_tdata[51:20]), .in_target(in_tdata[67:52]),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  rsie_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_pc(pc), .out_fault(flt), .out_wrote(wr),
    .out_value(val)
  );

  assign out_tdata = {6'd0, val, wr, flt, pc};

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(flt && wr)) else $error("fault with register write");
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !wr) |-> (val == 32'd0)) else $error("value without write");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");

endmodule

>>> verif/tb_riscv_subset_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// tb_riscv_subset_instruction_executor_unit: self-checking testbench
// Drives decoded instructions into the executor, predicts each result with
// its own register file, pc and memory model, and compares every result
// item field by field. Covers all operations, faults and several limits.
// ----------------------------------------------------------------------------
module tb_riscv_subset_instruction_executor_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rsie_pkg::*;

  typedef struct {
    logic [4:0]  mode;
    logic [4:0]  rd, ra, rb;
    logic [31:0] imm;
    logic [15:0] tgt;
    bit          typed;
    logic [15:0] pc;
    bit          flt, wr;
    logic [31:0] val;
  } instr_row_t;

  typedef struct {
    logic [15:0] pc;
    logic        flt, wr;
    logic [31:0] val;
  } retire_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_we = 0;
  logic [71:0] in_tdata = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_tready, out_tvalid;
  logic [55:0] out_tdata;

  riscv_subset_instruction_executor_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Shadow architectural state.
  logic [31:0] gpr [32];
  logic [15:0] pc_q;
  logic [7:0]  dmem [MEM_BYTES];
  bit          dmem_valid [MEM_BYTES];
  logic [15:0] sp_limit;
  int          stored_addrs[$];

  retire_t     pending[$];
  instr_row_t  directed[$];
  int          fails = 0, n_in = 0, n_out = 0, n_faults = 0, n_div = 0;
  bit          quiet = 0, long_hold_done = 0;
  int          idle_cycles = 0;

  function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b, bit rem, bit sgn);
    if (b == 0) return rem ? a : 32'hFFFF_FFFF;
    if (!sgn) return rem ? a % b : a / b;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return rem ? 32'd0 : 32'h8000_0000;
    return rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
  endfunction

  function automatic longint mem_addr(logic [31:0] base, logic [31:0] off);
    return longint'($signed(base)) + longint'($signed(off));
  endfunction

  function automatic bit mem_fault(logic [4:0] ra, logic [31:0] off);
    longint addr;
    addr = mem_addr(gpr[ra], off);
    return addr < 0 || addr > MEM_BYTES - 4 ||
           (ra == SP_REG && longint'($signed(off)) > longint'(sp_limit));
  endfunction

  // Executes one instruction on the shadow state and returns its result item.
  function automatic retire_t execute(instr_row_t r);
    retire_t     res;
    logic [31:0] a, b, v;
    logic [15:0] npc;
    bit          wr;
    int          p;
    a = gpr[r.ra];
    b = gpr[r.rb];
    v = 0;
    wr = 1;
    npc = pc_q;
    case (r.mode)
      OP_LI, OP_LA: v = r.imm;
      OP_MV:   v = a;
      OP_ADD:  v = a + b;
      OP_ADDI: v = a + r.imm;
      OP_SUB:  v = a - b;
      OP_MUL:  v = a * b;
      OP_DIV:  v = divide(a, b, 0, 1);
      OP_DIVU: v = divide(a, b, 0, 0);
      OP_REM:  v = divide(a, b, 1, 1);
      OP_UREM: v = divide(a, b, 1, 0);
      OP_SLLI: v = a << r.imm[4:0];
      OP_XOR:  v = a ^ b;
      OP_XORI: v = a ^ r.imm;
      OP_SEQZ: v = (a == 0);
      OP_SNEZ: v = (a != 0);
      OP_SLT:  v = ($signed(a) < $signed(b));
      OP_SGT:  v = ($signed(a) > $signed(b));
      OP_J:    begin wr = 0; npc = r.tgt; end
      OP_BNEZ: begin wr = 0; if (gpr[r.rd] != 0) npc = r.tgt; end
      OP_JAL:  begin v = {16'd0, pc_q}; npc = r.tgt; end
      OP_RET:  begin wr = 0; npc = gpr[RA_REG][15:0]; end
      OP_LW, OP_SW: begin
        if (mem_fault(r.ra, r.imm)) begin
          res = '{pc_q, 1'b1, 1'b0, 32'd0};
          return res;
        end
        p = int'(mem_addr(a, r.imm));
        if (r.mode == OP_LW) begin
          v = {dmem[p+3], dmem[p+2], dmem[p+1], dmem[p]};
        end else begin
          wr = 0;
          {dmem[p+3], dmem[p+2], dmem[p+1], dmem[p]} = gpr[r.rd];
          for (int i = 0; i < 4; i++) dmem_valid[p+i] = 1;
          stored_addrs.push_back(p);
        end
      end
      default: wr = 0;
    endcase
    if (wr) gpr[r.rd] = v;
    else v = 0;
    pc_q = npc + 16'd1;
    res = '{pc_q, 1'b0, wr, v};
    return res;
  endfunction

  function automatic instr_row_t mk(logic [4:0] mode, logic [4:0] rd, logic [4:0] ra,
                                    logic [4:0] rb, logic [31:0] imm, logic [15:0] tgt,
                                    bit typed = 0, logic [15:0] pc = 0, bit flt = 0,
                                    bit wr = 0, logic [31:0] val = 0);
    instr_row_t r;
    r = '{mode, rd, ra, rb, imm, tgt, typed, pc, flt, wr, val};
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 0;
      4, 5, 6: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  // Random instruction; loads and stores mostly aim at real addresses.
  function automatic instr_row_t random_instr();
    instr_row_t r;
    int  w, addr;
    bit  ok;
    r = mk($urandom_range(0, 23), $urandom, $urandom, $urandom, $urandom, $urandom);
    w = $urandom_range(0, 99);
    if (w < 15) begin
      r.mode = (w < 8) ? OP_LI : OP_LA;
      r.imm = pick_value();
    end else if (w < 30) begin
      r.mode = OP_LW + $urandom_range(0, 1);
      if ($urandom_range(0, 3) != 0) begin
        if (r.mode == OP_LW && stored_addrs.size() > 0)
          addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
        else
          addr = ($urandom_range(0, 7) == 0) ? MEM_BYTES - 4 : $urandom_range(0, 255);
        if ($urandom_range(0, 2) == 0) r.ra = SP_REG;
        r.imm = addr - gpr[r.ra];
      end
    end else if (w < 34) begin
      r.mode = 24 + $urandom_range(0, 7);
    end else if (w < 40) begin
      r.mode = OP_DIV + $urandom_range(0, 3);
    end
    if (r.mode == OP_LW && !mem_fault(r.ra, r.imm)) begin
      addr = int'(mem_addr(gpr[r.ra], r.imm));
      ok = 1;
      for (int i = 0; i < 4; i++) ok &= dmem_valid[addr+i];
      // Never read bytes that were not written: force a negative address.
      if (!ok) r.imm = 32'h8000_0000;
    end
    return r;
  endfunction

  task automatic send(instr_row_t r);
    retire_t e;
    e = execute(r);
    if (r.typed) e = '{r.pc, r.flt, r.wr, r.val};
    pending.push_back(e);
    if (r.mode inside {OP_DIV, OP_DIVU, OP_REM, OP_UREM}) n_div++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'd0, r.tgt, r.imm, r.rb, r.ra, r.rd, r.mode};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_and_configure(logic [15:0] limit);
    in_tvalid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 0;
    sp_limit = limit;
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_tvalid && in_tready) n_in <= n_in + 1;
      if (out_tvalid && out_tready) begin
        n_out <= n_out + 1;
        if (pending.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          retire_t e;
          e = pending.pop_front();
          if (e.flt) n_faults++;
          if (out_tdata[15:0] !== e.pc) begin
            $error("next_pc: expected %0d, got %0d", e.pc, out_tdata[15:0]); fails++;
          end
          if (out_tdata[16] !== e.flt) begin
            $error("fault: expected %0d, got %0d", e.flt, out_tdata[16]); fails++;
          end
          if (out_tdata[17] !== e.wr) begin
            $error("wrote_reg: expected %0d, got %0d", e.wr, out_tdata[17]); fails++;
          end
          if (out_tdata[49:18] !== e.val) begin
            $error("write_value: expected %h, got %h", e.val, out_tdata[49:18]); fails++;
          end
        end
      end
      if (idle_cycles > 3000) begin
        $display("riscv_subset_instruction_executor_unit regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the input queue fills.
  initial begin
    @(posedge rst_n);
    forever begin
      if (!long_hold_done && n_in >= 400) begin
        long_hold_done = 1;
        out_tready <= 0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] limits [5];
    for (int i = 0; i < 32; i++) gpr[i] = 0;
    pc_q = 0;
    sp_limit = STACK_LIMIT_RST;
    limits = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd1024};
    limits[3] = $urandom;

    // Division corners, faults at each memory bound, jumps and wrap of pc.
    directed.push_back(mk(OP_LI, 5, 0, 0, 32'h8000_0000, 0, 1, 1, 0, 1, 32'h8000_0000));
    directed.push_back(mk(OP_LI, 6, 0, 0, 32'hFFFF_FFFF, 0, 1, 2, 0, 1, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_DIV, 7, 5, 6, 0, 0, 1, 3, 0, 1, 32'h8000_0000));
    directed.push_back(mk(OP_REM, 8, 5, 6, 0, 0, 1, 4, 0, 1, 32'd0));
    directed.push_back(mk(OP_DIV, 9, 5, 0, 0, 0, 1, 5, 0, 1, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_DIVU, 10, 5, 0, 0, 0, 1, 6, 0, 1, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_REM, 11, 5, 0, 0, 0, 1, 7, 0, 1, 32'h8000_0000));
    directed.push_back(mk(OP_UREM, 12, 6, 0, 0, 0, 1, 8, 0, 1, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_LA, 13, 0, 0, 32'h7FFF_FFFF, 0, 1, 9, 0, 1, 32'h7FFF_FFFF));
    directed.push_back(mk(OP_LI, 20, 0, 0, 100, 0));
    directed.push_back(mk(OP_SW, 5, 20, 0, 0, 0, 1, 11, 0, 0, 0));
    directed.push_back(mk(OP_LW, 14, 20, 0, 0, 0, 1, 12, 0, 1, 32'h8000_0000));
    directed.push_back(mk(OP_LW, 15, 20, 0, -200, 0, 1, 12, 1, 0, 0));
    directed.push_back(mk(OP_LI, SP_REG, 0, 0, 0, 0));
    directed.push_back(mk(OP_SW, 5, SP_REG, 0, 1025, 0, 1, 13, 1, 0, 0));
    directed.push_back(mk(OP_SW, 6, 20, 0, 65432, 0, 1, 14, 0, 0, 0));
    directed.push_back(mk(OP_SW, 6, 20, 0, 65433, 0, 1, 14, 1, 0, 0));
    directed.push_back(mk(OP_MUL, 16, 5, 6, 0, 0));
    directed.push_back(mk(OP_ADD, 17, 5, 6, 0, 0));
    directed.push_back(mk(OP_SUB, 18, 6, 5, 0, 0));
    directed.push_back(mk(OP_SLLI, 19, 6, 0, 32'hFFFF_FFE1, 0));
    directed.push_back(mk(OP_XOR, 21, 5, 6, 0, 0));
    directed.push_back(mk(OP_XORI, 22, 5, 0, 32'h7FFF_FFFF, 0));
    directed.push_back(mk(OP_SEQZ, 23, 0, 0, 0, 0));
    directed.push_back(mk(OP_SNEZ, 24, 5, 0, 0, 0));
    directed.push_back(mk(OP_SLT, 25, 5, 6, 0, 0));
    directed.push_back(mk(OP_SGT, 26, 5, 6, 0, 0));
    directed.push_back(mk(OP_MV, 27, 5, 0, 0, 0));
    directed.push_back(mk(OP_ADDI, 28, 6, 0, 1, 0));
    directed.push_back(mk(OP_J, 0, 0, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0));
    directed.push_back(mk(OP_BNEZ, 5, 0, 0, 0, 40, 1, 41, 0, 0, 0));
    directed.push_back(mk(OP_BNEZ, 0, 0, 0, 0, 99, 1, 42, 0, 0, 0));
    directed.push_back(mk(OP_JAL, RA_REG, 0, 0, 0, 7, 1, 8, 0, 1, 32'd42));
    directed.push_back(mk(OP_LI, RA_REG, 0, 0, 32'h0001_0005, 0));
    directed.push_back(mk(OP_RET, 0, 0, 0, 0, 0, 1, 6, 0, 0, 0));
    directed.push_back(mk(5'd31, 0, 0, 0, 0, 0, 1, 7, 0, 0, 0));
    directed.push_back(mk(5'd24, 3, 4, 5, 32'hFFFF_FFFF, 16'hFFFF));

    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_configure(limits[ph]);
      for (int k = 0; k < 275; k++) begin
        if (ph == 4 && k >= 125) quiet = 1;
        // One pause until the executor has returned every result.
        if (ph == 2 && k == 100) begin
          in_tvalid <= 0;
          while (pending.size() != 0) @(posedge clk);
        end
        send(random_instr());
      end
    end
    in_tvalid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Executed %0d instructions (%0d divides, %0d memory faults), %0d results checked,",
             n_in, n_div, n_faults, n_out);
    $display("over five stack offset limits including 0 and 65535.");
    if (fails == 0)
      $display("riscv_subset_instruction_executor_unit regression: pass");
    else
      $display("riscv_subset_instruction_executor_unit regression: fail");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/rsie_pkg.sv
hw/rtl/rsie_front.sv
hw/rtl/rsie_div.sv
hw/rtl/rsie_back.sv
hw/rtl/riscv_subset_instruction_executor_unit.sv
verif/tb_riscv_subset_instruction_executor_unit.sv
